// ===== design/sdiv_pkg.sv =====
// Package for the signed restoring divider: data width, operand type and the
// sign and special-case flags that travel down the pipeline with each item.
// No dependencies.
package sdiv_pkg;

  localparam int DATA_WIDTH = 32;

  typedef logic [DATA_WIDTH-1:0] data_t;

  localparam data_t INT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic neg_q;  // operand signs differ
    logic neg_r;  // dividend negative
    logic div0;   // divisor is zero
    logic ovf;    // most negative value over minus one
  } sdiv_flags_t;

endpackage

// ===== design/signed_restoring_divider.sv =====
// Top level of the signed restoring divider: a fully pipelined shift-subtract
// divider, one quotient bit per stage. Depends on sdiv_pkg.
//
//   channel  ports                                        direction
//   input    in_valid, in_ready, in_dividend, in_divisor   in  (ready out)
//   result   out_valid, out_ready, out_quotient,
//            out_remainder, out_overflow                   out (ready in)
//
// One division enters per cycle while in_ready is high; an item passes the input
// stage for magnitudes, one stage per quotient bit and the output stage for sign fix-up.
// Each bit stage holds a single subtract-and-compare.
// Reset (rst_n, synchronous) clears the valid bits only.
// The pipeline freezes only while the last bit stage and the output register
// both hold an item and the output side is not ready; nothing is lost then.
module signed_restoring_divider
  import sdiv_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] in_dividend,
  input  logic signed [DATA_WIDTH-1:0] in_divisor,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_quotient,
  output logic signed [DATA_WIDTH-1:0] out_remainder,
  output logic                         out_overflow
);

  localparam int W = DATA_WIDTH;

  // stage 0 is the input register, stage s holds the result of quotient bit s
  logic        v_r    [0:W];
  data_t       rem_r  [0:W];
  data_t       qn_r   [0:W];  // dividend bits shift out, quotient bits shift in
  data_t       d_r    [0:W];
  sdiv_flags_t flg_r  [0:W];

  data_t       rem_nxt [1:W];
  data_t       qn_nxt  [1:W];
  logic [W:0]  diff    [1:W];
  data_t       shifted [1:W];

  logic        ld_out;
  logic        en_pipe;

  logic        out_v_r;
  data_t       out_q_r;
  data_t       out_rem_r;
  logic        out_ovf_r;

  logic        sa;
  logic        sb;
  data_t       ma;
  data_t       mb;
  sdiv_flags_t in_flg;

  data_t       q_fix;
  data_t       r_fix;

  assign ld_out   = !out_v_r || out_ready;
  assign en_pipe  = !v_r[W] || ld_out;
  assign in_ready = en_pipe;

  // input stage: magnitudes and special cases
  always_comb begin
    sa           = in_dividend[W-1];
    sb           = in_divisor[W-1];
    ma           = sa ? data_t'(~in_dividend + data_t'(1)) : data_t'(in_dividend);
    mb           = sb ? data_t'(~in_divisor + data_t'(1)) : data_t'(in_divisor);
    in_flg.neg_q = sa ^ sb;
    in_flg.neg_r = sa;
    in_flg.div0  = (in_divisor == '0);
    in_flg.ovf   = (data_t'(in_dividend) == INT_MIN) && (in_divisor == '1);
  end

  // one restoring step per stage; a zero divisor leaves the dividend as remainder
  for (genvar s = 1; s <= W; s++) begin : g_step
    always_comb begin
      shifted[s] = {rem_r[s-1][W-2:0], qn_r[s-1][W-1]};
      diff[s]    = {1'b0, shifted[s]} - {1'b0, d_r[s-1]};
      rem_nxt[s] = diff[s][W] ? shifted[s] : diff[s][W-1:0];
      qn_nxt[s]  = {qn_r[s-1][W-2:0], !diff[s][W]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= W; s++) begin
        v_r[s] <= 1'b0;
      end
    end else if (en_pipe) begin
      v_r[0] <= in_valid;
      for (int s = 1; s <= W; s++) begin
        v_r[s] <= v_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_pipe) begin
      rem_r[0] <= '0;
      qn_r[0]  <= ma;
      d_r[0]   <= mb;
      flg_r[0] <= in_flg;
      for (int s = 1; s <= W; s++) begin
        rem_r[s] <= rem_nxt[s];
        qn_r[s]  <= qn_nxt[s];
        d_r[s]   <= d_r[s-1];
        flg_r[s] <= flg_r[s-1];
      end
    end
  end

  // output stage: sign fix-up, all ones quotient on a zero divisor
  always_comb begin
    if (flg_r[W].div0) begin
      q_fix = '1;
    end else if (flg_r[W].neg_q) begin
      q_fix = data_t'(~qn_r[W] + data_t'(1));
    end else begin
      q_fix = qn_r[W];
    end
    r_fix = flg_r[W].neg_r ? data_t'(~rem_r[W] + data_t'(1)) : rem_r[W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (ld_out) begin
      out_v_r <= v_r[W];
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_q_r   <= q_fix;
      out_rem_r <= r_fix;
      out_ovf_r <= flg_r[W].ovf;
    end
  end

  assign out_valid     = out_v_r;
  assign out_quotient  = out_q_r;
  assign out_remainder = out_rem_r;
  assign out_overflow  = out_ovf_r;

  // pipeline only freezes with a result held at the output
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    !en_pipe |-> out_v_r && v_r[W])
    else $error("pipeline stalled without a held result");

  // a frozen pipeline keeps its last bit stage
  a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    !en_pipe |=> v_r[W] && $stable(qn_r[W]) && $stable(rem_r[W]))
    else $error("last bit stage changed during a stall");

  // restoring invariant: remainder magnitude below divisor magnitude
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[W] && !flg_r[W].div0 |-> rem_r[W] < d_r[W])
    else $error("remainder not below divisor");

  // overflow case gives the most negative quotient and a zero remainder
  a_ovf_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> data_t'(out_quotient) == INT_MIN && out_remainder == '0)
    else $error("overflow result malformed");

endmodule

// ===== verif/sdiv_scoreboard_pkg.sv =====
`timescale 1ns / 100ps
// Scoreboard for the signed restoring divider testbench: predicts quotient,
// remainder and overflow for each accepted division and checks results in order.
// Depends on sdiv_pkg.
package sdiv_scoreboard_pkg;
  import sdiv_pkg::*;

  typedef struct packed {
    data_t dividend;
    data_t divisor;
    data_t quotient;
    data_t remainder;
    logic  overflow;
  } div_result_t;

  class sdiv_scoreboard;
    div_result_t expected_q[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // truncating signed division, done on magnitudes with one quotient bit per step
    function div_result_t predict_division(data_t a, data_t b);
      div_result_t res;
      data_t       mag_a;
      data_t       mag_b;
      data_t       part;
      data_t       quo;
      res.dividend = a;
      res.divisor  = b;
      res.overflow = 1'b0;
      if (b == '0) begin
        res.quotient  = '1;
        res.remainder = a;
      end else if (a == INT_MIN && b == '1) begin
        res.quotient  = INT_MIN;
        res.remainder = '0;
        res.overflow  = 1'b1;
      end else begin
        // INT_MIN negates to itself, which read unsigned is the right magnitude
        mag_a = a[DATA_WIDTH-1] ? -a : a;
        mag_b = b[DATA_WIDTH-1] ? -b : b;
        part  = '0;
        quo   = '0;
        for (int i = DATA_WIDTH - 1; i >= 0; i--) begin
          part = {part[DATA_WIDTH-2:0], mag_a[i]};
          if (part >= mag_b) begin
            part   = part - mag_b;
            quo[i] = 1'b1;
          end
        end
        res.quotient  = (a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1]) ? -quo : quo;
        res.remainder = a[DATA_WIDTH-1] ? -part : part;
      end
      return res;
    endfunction

    task report_mismatch(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    // append at the tail so results are checked in transfer order
    function void note_division(data_t a, data_t b);
      expected_q.insert(expected_q.size(), predict_division(a, b));
    endfunction

    task check_division(data_t q, data_t r, logic ovf);
      div_result_t exp_res;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result q=%h r=%h ovf=%b with no division outstanding",
                                  q, r, ovf));
      end else begin
        exp_res = expected_q.pop_front();
        if (q !== exp_res.quotient)
          report_mismatch($sformatf("%h / %h: quotient %h, expected %h",
                                    exp_res.dividend, exp_res.divisor, q, exp_res.quotient));
        if (r !== exp_res.remainder)
          report_mismatch($sformatf("%h / %h: remainder %h, expected %h",
                                    exp_res.dividend, exp_res.divisor, r, exp_res.remainder));
        if (ovf !== exp_res.overflow)
          report_mismatch($sformatf("%h / %h: overflow %b, expected %b",
                                    exp_res.dividend, exp_res.divisor, ovf, exp_res.overflow));
      end
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

// ===== verif/signed_restoring_divider_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for signed_restoring_divider: directed corner divisions, then
// random ones under varying source/sink stalls. Depends on sdiv_pkg and sdiv_scoreboard_pkg.
module signed_restoring_divider_tb;
  import sdiv_pkg::*;
  import sdiv_scoreboard_pkg::*;

  localparam int RANDOM_DIVS = 1700;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = DATA_WIDTH + 10;

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_ready;
  data_t in_dividend;
  data_t in_divisor;
  logic  out_valid;
  logic  out_ready;
  data_t out_quotient;
  data_t out_remainder;
  logic  out_overflow;

  int          send_idle_pct;
  int          recv_idle_pct;
  int unsigned cycle_count;
  sdiv_scoreboard sb;

  signed_restoring_divider i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_dividend  (in_dividend),
    .in_divisor   (in_divisor),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_quotient (out_quotient),
    .out_remainder(out_remainder),
    .out_overflow (out_overflow)
  );

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_dividend   = '0;
    in_divisor    = '0;
    out_ready     = 1'b0;
    send_idle_pct = 30;
    recv_idle_pct = 85;
    cycle_count   = 0;
    sb            = new();
  end

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("signed_restoring_divider_tb NOT OK");
      $finish;
    end
  end

  // sink stalls
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // observe transfers on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_division(in_dividend, in_divisor);
      if (out_valid && out_ready)
        sb.check_division(out_quotient, out_remainder, out_overflow);
    end
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic push_division(input data_t a, input data_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_dividend <= a;
    in_divisor  <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic data_t random_operand();
    data_t v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = data_t'($urandom);
      4, 5:       v = data_t'($urandom_range(32)) - data_t'(16);
      6: begin
        case ($urandom_range(4))
          0:       v = '0;
          1:       v = data_t'(1);
          2:       v = '1;
          3:       v = INT_MIN;
          default: v = ~INT_MIN;
        endcase
      end
      default: begin
        // spread magnitudes so quotients of every length show up
        v = data_t'($urandom) >> $urandom_range(DATA_WIDTH - 1);
        if ($urandom_range(1) == 1)
          v = -v;
      end
    endcase
    return v;
  endfunction

  initial begin
    data_t dir_a[$];
    data_t dir_b[$];
    int    send_pct[3];
    int    recv_pct[3];
    send_pct = '{30, 85, 0};
    recv_pct = '{85, 30, 0};

    // divide by zero, the overflow case, most negative operands, sign combos
    dir_a = '{32'sd0, INT_MIN, ~INT_MIN, '1, 32'sd7,
              INT_MIN, INT_MIN, INT_MIN, INT_MIN, ~INT_MIN, ~INT_MIN, ~INT_MIN,
              32'sd7, -32'sd7, 32'sd7, -32'sd7, 32'sd0, 32'sd1, '1, INT_MIN,
              32'sd5, -32'sd5};
    dir_b = '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
              '1, 32'sd1, INT_MIN, ~INT_MIN, INT_MIN, '1, ~INT_MIN,
              32'sd2, 32'sd2, -32'sd2, -32'sd2, '1, INT_MIN, INT_MIN, 32'sd2,
              32'sd1234567, -32'sd1234567};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_a[i])
      push_division(dir_a[i], dir_b[i]);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct <= send_pct[ph];
      recv_idle_pct <= recv_pct[ph];
      for (int n = 0; n < RANDOM_DIVS / 3; n++)
        push_division(random_operand(), random_operand());
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0)
      $display("signed_restoring_divider_tb OK");
    else
      $display("signed_restoring_divider_tb NOT OK");
    $finish;
  end

endmodule
